[rtl/bpm_pkg.sv]
package bpm_pkg;

    // Letter index width, a = 0 through z = 25
    localparam int LETTER_W = 5;

    // Stream word widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    // Word kind carried in tuser
    typedef enum logic
    {
        OP_PATTERN = 1'b0,
        OP_WORD    = 1'b1
    } op_t;

    typedef logic [LETTER_W-1:0] letter_t;

endpackage

[rtl/bijective_pattern_matcher.sv]
// Channel   | Dir | tdata (low bit up)          | tuser      | tlast
// ----------+-----+-----------------------------+------------+----------------------
// s_axis    | in  | letter[4:0], zeros [7:5]    | op[0]      | last letter of run
// m_axis    | out | matched[0], zeros [7:1]     | -          | -
//
// One input word per cycle sustained; a stalled result blocks only when a second
// result reaches the check stage behind it.
// A word's last letter, when accepted, loads the check stage and the pattern memory
// read register; the map check then loads the output register once that register
// has room, and the result is offered on m_axis from there.
// Reset (rst_n low, asynchronous) empties the pattern, the word state, both map
// valid vectors and both pipeline stages; pattern and map payloads are not cleared.
// s_axis_tready drops only while a result sits in the check stage and the output
// register is full and not being taken.
module bijective_pattern_matcher #(
    parameter int MAX_LEN  = 32,
    parameter int ALPHABET = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] letter, [7:5] zero
    input  logic [bpm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,
    // [0] op
    input  logic [bpm_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] matched, [7:1] zero
    output logic [bpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import bpm_pkg::*;

    // Pattern length counts 0..MAX_LEN, word position saturates at MAX_LEN + 1
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW = $clog2(ALPHABET);

    localparam logic [LW-1:0]       MAX_LEN_L = LW'(MAX_LEN);
    localparam logic [CW-1:0]       MAX_LEN_C = CW'(MAX_LEN);
    localparam logic [LETTER_W-1:0] ALPHA_L   = LETTER_W'(ALPHABET);

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    op_t     in_op;
    letter_t in_letter;
    logic    in_fire;
    logic    pat_fire;
    logic    word_fire;

    assign in_op     = op_t'(s_axis_tuser[0]);
    assign in_letter = s_axis_tdata[LETTER_W-1:0];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign pat_fire  = in_fire && (in_op == OP_PATTERN);
    assign word_fire = in_fire && (in_op == OP_WORD);

    // ------------------------------------------------------------------
    // Pattern store and word position (first stage)
    // ------------------------------------------------------------------
    letter_t          pat_mem [MAX_LEN];
    logic [LW-1:0]    pat_len_reg, pat_len_next;
    logic             pat_complete_reg, pat_complete_next;
    logic             pat_ovf_reg, pat_ovf_next;
    logic [CW-1:0]    word_pos_reg, word_pos_next;
    logic [LW-1:0]    len_base;
    logic             pat_room;
    logic [CW-1:0]    len_ext;
    logic             pos_in_mem;

    // A pattern letter after a complete pattern starts a new one
    assign len_base   = pat_complete_reg ? '0 : pat_len_reg;
    assign pat_room   = (len_base < MAX_LEN_L);
    assign len_ext    = CW'(pat_len_reg);
    assign pos_in_mem = (word_pos_reg < MAX_LEN_C);

    always_comb
    begin
        pat_len_next      = pat_len_reg;
        pat_complete_next = pat_complete_reg;
        pat_ovf_next      = pat_ovf_reg;
        word_pos_next     = word_pos_reg;
        if (pat_fire)
        begin
            pat_len_next      = pat_room ? len_base + 1'b1 : len_base;
            pat_ovf_next      = (pat_complete_reg ? 1'b0 : pat_ovf_reg) | ~pat_room;
            pat_complete_next = s_axis_tlast;
            // abandon any partly checked word
            word_pos_next     = '0;
        end
        else if (word_fire)
        begin
            if (s_axis_tlast)
                word_pos_next = '0;
            else if (word_pos_reg <= MAX_LEN_C)
                word_pos_next = word_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg      <= '0;
            pat_complete_reg <= 1'b0;
            pat_ovf_reg      <= 1'b0;
            word_pos_reg     <= '0;
        end
        else
        begin
            pat_len_reg      <= pat_len_next;
            pat_complete_reg <= pat_complete_next;
            pat_ovf_reg      <= pat_ovf_next;
            word_pos_reg     <= word_pos_next;
        end
    end

    // Pattern memory: one write port, one registered read port
    letter_t plet_reg;

    always_ff @(posedge clk)
    begin
        if (pat_fire && pat_room)
            pat_mem[len_base[PW-1:0]] <= in_letter;
        if (word_fire && pos_in_mem)
            plet_reg <= pat_mem[word_pos_reg[PW-1:0]];
    end

    // ------------------------------------------------------------------
    // Check stage registers
    // ------------------------------------------------------------------
    logic          st_valid_reg, st_valid_next;
    letter_t       st_letter_reg;
    logic          st_last_reg;
    logic          st_start_reg;
    logic          st_in_range_reg;
    logic          st_final_ok_reg;
    logic          st_adv;
    logic          out_valid_reg, out_valid_next;
    logic          out_matched_reg;
    logic [CW:0]   pos_inc;

    // Word position after this letter, one bit wider so it cannot wrap
    assign pos_inc = {1'b0, word_pos_reg} + 1'b1;

    // Letters without a result always move on; a result needs room at the output
    assign st_adv        = st_valid_reg && (!st_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !st_valid_reg || st_adv;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (in_fire)
            st_valid_next = (in_op == OP_WORD);
        else if (st_adv)
            st_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (word_fire)
        begin
            st_letter_reg   <= in_letter;
            st_last_reg     <= s_axis_tlast;
            st_start_reg    <= (word_pos_reg == '0);
            st_in_range_reg <= pat_complete_reg && !pat_ovf_reg &&
                               (word_pos_reg < len_ext) && pos_in_mem;
            st_final_ok_reg <= pat_complete_reg && !pat_ovf_reg &&
                               (pos_inc == (CW+1)'(pat_len_reg));
        end
    end

    // ------------------------------------------------------------------
    // Bijection check (second stage)
    // ------------------------------------------------------------------
    logic [AW-1:0]       fwd_map_reg [ALPHABET];
    logic [AW-1:0]       rev_map_reg [ALPHABET];
    logic [ALPHABET-1:0] fwd_valid_reg, fwd_valid_next;
    logic [ALPHABET-1:0] rev_valid_reg, rev_valid_next;
    logic                failed_reg, failed_next;

    logic          fail_cur;
    logic          both_ok;
    logic [AW-1:0] wi;
    logic [AW-1:0] pi;
    logic          fv;
    logic          rv;
    logic          fresh;
    logic          same;
    logic          pair_ok;
    logic          fail_new;
    logic          do_bind;

    // The first letter of a word sees empty maps and no earlier failure
    assign fail_cur = st_start_reg ? 1'b0 : failed_reg;
    assign both_ok  = (st_letter_reg < ALPHA_L) && (plet_reg < ALPHA_L);
    assign wi       = st_letter_reg[AW-1:0];
    assign pi       = plet_reg[AW-1:0];
    assign fv       = both_ok && !st_start_reg && fwd_valid_reg[wi];
    assign rv       = both_ok && !st_start_reg && rev_valid_reg[pi];
    assign fresh    = !fv && !rv;
    assign same     = fv && rv && (fwd_map_reg[wi] == pi) && (rev_map_reg[pi] == wi);
    assign pair_ok  = both_ok && (fresh || same);
    assign fail_new = fail_cur || !st_in_range_reg || !pair_ok;
    assign do_bind  = st_adv && !fail_cur && st_in_range_reg && both_ok && fresh;

    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        rev_valid_next = rev_valid_reg;
        failed_next    = failed_reg;
        if (st_adv)
        begin
            if (st_start_reg)
            begin
                fwd_valid_next = '0;
                rev_valid_next = '0;
            end
            if (do_bind)
            begin
                fwd_valid_next[wi] = 1'b1;
                rev_valid_next[pi] = 1'b1;
            end
            failed_next = st_last_reg ? 1'b0 : fail_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= '0;
            rev_valid_reg <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
            rev_valid_reg <= rev_valid_next;
            failed_reg    <= failed_next;
        end
    end

    // Record a new letter pair in both directions
    always_ff @(posedge clk)
    begin
        if (do_bind)
        begin
            fwd_map_reg[wi] <= pi;
            rev_map_reg[pi] <= wi;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (st_adv && st_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_adv && st_last_reg)
            out_matched_reg <= !fail_new && st_final_ok_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_matched_reg};

endmodule

[rtl/bpm_checker.sv]
module bpm_port_checks (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [bpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           s_axis_tlast,
    input logic [bpm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import bpm_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Drop ready only behind a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A fresh result follows the acceptance of a word's last letter
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast &&
                  (s_axis_tuser[0] == OP_WORD) && (s_axis_tdata[7:5] == 3'b000 ||
                   s_axis_tdata[7:5] != 3'b000), 2))
        else $error("result without a finished word");

    // Keep the padding bits of a result at zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind bijective_pattern_matcher bpm_port_checks u_bpm_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/bpm_checker.sv]
module bpm_checker #(
    parameter int MAX_LEN  = 32,
    parameter int ALPHABET = 26
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // [4:0] letter, [7:5] zero
    input  logic [bpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    // [0] op
    input  logic [bpm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] matched, [7:1] zero
    input  logic [bpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             mismatch_count,
    output int                             results_outstanding
);

    import bpm_pkg::*;

    // Shadow copy of the matcher state
    letter_t    pat_mem [MAX_LEN];
    logic [5:0] pat_len;
    logic       pat_done;
    logic       pat_over;
    logic [5:0] word_pos;
    logic       word_bad;
    letter_t    fwd_map [ALPHABET];
    logic       fwd_ok  [ALPHABET];
    letter_t    rev_map [ALPHABET];
    logic       rev_ok  [ALPHABET];

    // Match flags still owed by the block, oldest first
    bit         match_queue[$];

    function automatic void clear_maps();
        for (int i = 0; i < ALPHABET; i++)
        begin
            fwd_ok[i] = 1'b0;
            rev_ok[i] = 1'b0;
        end
    endfunction

    // Pair a word letter with a pattern letter; 0 on conflict or a letter past the alphabet
    function automatic bit pair_ok(letter_t w, letter_t p);
        if (w >= ALPHABET || p >= ALPHABET)
            return 1'b0;
        if (!fwd_ok[w] && !rev_ok[p])
        begin
            fwd_map[w] = p;
            fwd_ok[w]  = 1'b1;
            rev_map[p] = w;
            rev_ok[p]  = 1'b1;
            return 1'b1;
        end
        return fwd_ok[w] && rev_ok[p] && fwd_map[w] == p && rev_map[p] == w;
    endfunction

    function automatic void predict_letter(op_t op, letter_t ltr, logic lst);
        if (op == OP_PATTERN)
        begin
            if (pat_done)
            begin
                pat_len  = '0;
                pat_done = 1'b0;
                pat_over = 1'b0;
            end
            if (pat_len < MAX_LEN)
            begin
                pat_mem[pat_len] = ltr;
                pat_len          = pat_len + 1'b1;
            end
            else
                pat_over = 1'b1;
            if (lst)
                pat_done = 1'b1;
            word_pos = '0;
            word_bad = 1'b0;
            return;
        end
        if (word_pos == 0)
        begin
            clear_maps();
            word_bad = 1'b0;
        end
        if (!pat_done || pat_over || word_pos >= pat_len || word_pos >= MAX_LEN)
            word_bad = 1'b1;
        else if (!word_bad)
        begin
            if (!pair_ok(ltr, pat_mem[word_pos]))
                word_bad = 1'b1;
        end
        if (word_pos <= MAX_LEN)
            word_pos = word_pos + 1'b1;
        if (lst)
        begin
            match_queue.insert(match_queue.size(),
                               !word_bad && pat_done && !pat_over &&
                               word_pos == pat_len);
            word_pos = '0;
            word_bad = 1'b0;
        end
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            pat_len        = '0;
            pat_done       = 1'b0;
            pat_over       = 1'b0;
            word_pos       = '0;
            word_bad       = 1'b0;
            clear_maps();
            match_queue.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_letter(op_t'(s_axis_tuser[0]), s_axis_tdata[LETTER_W-1:0],
                               s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (match_queue.size() == 0)
                    flag_error($sformatf("result with nothing expected: matched %0b",
                                         m_axis_tdata[0]));
                else
                begin
                    want = match_queue.pop_front();
                    if (m_axis_tdata[0] !== want)
                        flag_error($sformatf("matched mismatch: expected %0b actual %0b",
                                             want, m_axis_tdata[0]));
                end
            end
        end
        results_outstanding = match_queue.size();
    end

endmodule

[tb/bijective_pattern_matcher_tb.sv]
module bijective_pattern_matcher_tb;

    import bpm_pkg::*;

    localparam int MAX_LEN   = 32;
    localparam int ALPHABET  = 26;
    localparam int ITEM_GOAL = 1200;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [4:0] letter, [7:5] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    // [0] op
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] matched, [7:1] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int results_outstanding;

    // Idle percentages per side, changed between phases
    int tx_idle_pct = 34;
    int rx_idle_pct = 69;
    // Cycles the receiver still has to hold off
    int hold_left   = 0;
    int sent_count  = 0;

    // Generator view of the last pattern sent and the word being built
    letter_t gen_pat[$];
    letter_t word_buf[$];
    letter_t perm[ALPHABET];

    bijective_pattern_matcher #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bpm_checker #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tlast        (s_axis_tlast),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: hold off while a stall is requested, else take results at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one word after a random number of idle cycles and hold it until taken.
    // Valid drops only on an idle cycle, so it never toggles within one step.
    task automatic send_letter(input op_t op, input letter_t ltr, input logic lst);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-LETTER_W){1'b0}}, ltr};
        s_axis_tuser  <= op;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    // Stream a pattern; letters come from a narrow span to force repeats,
    // now and then from the full 5-bit range to hit letters past z
    task automatic send_pattern(input int len);
        int      span;
        bit      wide;
        letter_t ltr;
        span = $urandom_range(ALPHABET, 2);
        wide = ($urandom_range(99) < 20);
        gen_pat.delete();
        for (int i = 0; i < len; i++)
        begin
            ltr = wide ? letter_t'($urandom_range(31)) : letter_t'($urandom_range(span - 1));
            gen_pat.insert(gen_pat.size(), ltr);
            send_letter(OP_PATTERN, ltr, i == len - 1);
        end
    endtask

    task automatic send_random_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            send_pattern($urandom_range(8, 1));
        else if (r < 90)
            send_pattern($urandom_range(MAX_LEN, 9));
        else
            send_pattern($urandom_range(MAX_LEN + 8, MAX_LEN + 1));
    endtask

    // Build a word that is a letter permutation of the stored pattern
    task automatic build_match();
        int      j;
        letter_t tmp;
        for (int i = 0; i < ALPHABET; i++)
            perm[i] = letter_t'(i);
        for (int i = ALPHABET - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        word_buf.delete();
        foreach (gen_pat[i])
            word_buf.insert(word_buf.size(),
                            gen_pat[i] < ALPHABET ? perm[gen_pat[i]]
                                                  : letter_t'($urandom_range(31)));
        if (word_buf.size() == 0)
            word_buf.insert(word_buf.size(), letter_t'($urandom_range(31)));
    endtask

    task automatic send_word();
        foreach (word_buf[i])
            send_letter(OP_WORD, word_buf[i], i == word_buf.size() - 1);
    endtask

    initial
    begin
        int r;
        int k;
        bit burst_done;
        burst_done = 1'b0;

        // Single reset pulse
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: word before any pattern
        send_letter(OP_WORD, letter_t'(0), 1'b1);
        // Pattern "abba"
        send_letter(OP_PATTERN, letter_t'(0), 1'b0);
        send_letter(OP_PATTERN, letter_t'(1), 1'b0);
        send_letter(OP_PATTERN, letter_t'(1), 1'b0);
        send_letter(OP_PATTERN, letter_t'(0), 1'b1);
        gen_pat = '{letter_t'(0), letter_t'(1), letter_t'(1), letter_t'(0)};
        // "xyyx" matches
        word_buf = '{letter_t'(23), letter_t'(24), letter_t'(24), letter_t'(23)};
        send_word();
        // "xyyz" breaks the pairing on the last letter
        word_buf = '{letter_t'(23), letter_t'(24), letter_t'(24), letter_t'(25)};
        send_word();
        // Short word
        word_buf = '{letter_t'(23), letter_t'(24)};
        send_word();
        // Long word
        word_buf = '{letter_t'(23), letter_t'(24), letter_t'(24), letter_t'(23),
                     letter_t'(23)};
        send_word();
        // Letter beyond the alphabet
        word_buf = '{letter_t'(31), letter_t'(24), letter_t'(24), letter_t'(31)};
        send_word();

        // Random part: mostly well-formed words against fresh patterns
        send_random_pattern();
        while (sent_count < ITEM_GOAL)
        begin
            if (sent_count >= 2 * ITEM_GOAL / 3 && !burst_done)
            begin
                // Last phase: no idling; start with a long receiver hold-off
                // while one-letter words pile up and back-pressure the input
                burst_done  = 1'b1;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                send_pattern(1);
                hold_left = 300;
                for (int i = 0; i < 30; i++)
                    send_letter(OP_WORD, letter_t'($urandom_range(31)), 1'b1);
            end
            else if (sent_count >= ITEM_GOAL / 3 && !burst_done)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 34;
            end

            r = $urandom_range(99);
            if (r < 15)
                send_random_pattern();
            else if (r < 55)
            begin
                build_match();
                send_word();
            end
            else if (r < 70)
            begin
                // Corrupt one letter
                build_match();
                word_buf[$urandom_range(word_buf.size() - 1)] = letter_t'($urandom_range(31));
                send_word();
            end
            else if (r < 80)
            begin
                // Wrong length by one
                build_match();
                if (word_buf.size() > 1 && $urandom_range(1))
                    void'(word_buf.pop_back());
                else
                    word_buf.insert(word_buf.size(), letter_t'($urandom_range(31)));
                send_word();
            end
            else if (r < 88)
            begin
                // Abandon a word part way with a new pattern
                build_match();
                k = $urandom_range(word_buf.size(), 1);
                for (int i = 0; i < k; i++)
                    send_letter(OP_WORD, word_buf[i], 1'b0);
                send_random_pattern();
            end
            else
            begin
                // Noise: any op, any letter, any last
                k = $urandom_range(4, 1);
                for (int i = 0; i < k; i++)
                    send_letter(op_t'($urandom_range(1)), letter_t'($urandom_range(31)),
                                logic'($urandom_range(1)));
            end
        end

        // Drop valid and drain the outstanding results
        s_axis_tvalid <= 1'b0;
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && results_outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/bpm_pkg.sv
rtl/bijective_pattern_matcher.sv
rtl/bpm_checker.sv
tb/bpm_checker.sv
tb/bijective_pattern_matcher_tb.sv
